### src/skmp_pkg.sv
package skmp_pkg;

  localparam int MAX_BONES_DEF = 64;
  localparam int FRAC_BITS_DEF = 16;

  localparam int IN_DATA_W  = 272;
  localparam int OUT_DATA_W = 136;

endpackage

### src/skinning_matrix_palette_core.sv
// Skeletal skinning palette engine, 3x4 packed rows, signed fixed point.
// Each input beat carries one column (0..3) of a bone's local pose and
// inverse bind pose; the beat with column 3 completes the bone. Bones come
// parents first. A completed bone gets its world pose (parent world times
// local, or local for a root, or for a parent index not below its own) and
// that pose is kept in an on-chip pose cache of MAX_BONES*16 words. A deform
// bone with skinning enabled then yields three output beats, one row of
// world times inverse bind each, tlast on the third, with a running slot.
// Products are rounded to nearest and saturated, and so are dot sums.
// Flow: beats for columns 0..2 leave the block ready. A completing beat
// occupies the block for the whole bone: one shared 32x32 multiplier takes
// each product through S_RD, S_MUL and S_ACC, four products per word, for
// 16 words with a parent (a root is copied) and 12 more for a deform bone,
// plus the wait for each output beat. No input beat is taken meanwhile.
module skinning_matrix_palette_core #(
  parameter int MAX_BONES = skmp_pkg::MAX_BONES_DEF,
  parameter int FRAC_BITS = skmp_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [0:0]                      cfg_data,   // skinning_enable
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // column_index, parent_bone, deform_flag, local_pose_r0..r3, inv_bind_r0..r3
  input  logic [skmp_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [0:0]                      in_tuser,   // first_bone
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // palette_slot, palette_row, value_c0..value_c3
  output logic [skmp_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                            out_tlast   // last_row
);
  import skmp_pkg::*;

  localparam int BW    = $clog2(MAX_BONES + 1);
  localparam int DEPTH = MAX_BONES * 16;
  localparam int AW    = $clog2(DEPTH);
  localparam logic signed [64:0] RND  = 65'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [64:0] PMAX = 65'sd2147483647;
  localparam logic signed [64:0] PMIN = -65'sd2147483648;
  localparam logic signed [33:0] SMAX = 34'sd2147483647;
  localparam logic signed [33:0] SMIN = -34'sd2147483648;

  typedef enum logic [2:0] {S_IDLE, S_RD, S_MUL, S_ACC, S_OUT} state_t;

  state_t             state_r;
  logic               enable_r;
  logic [BW-1:0]      bone_r;
  logic [5:0]         slot_r;
  logic [BW-1:0]      bone_idx_r;
  logic [5:0]         parent_r;
  logic               root_r;
  logic               fin_go_r;
  logic               phb_r;
  logic [1:0]         c_r, r_r, k_r;
  logic signed [31:0] opa_r;
  logic signed [63:0] prod_r;
  logic signed [33:0] acc_r;
  logic signed [31:0] outv_r [4];
  logic [5:0]         oslot_r;
  logic               out_valid_r;

  logic signed [31:0] lbuf [16];
  logic signed [31:0] ibuf [16];
  logic signed [31:0] wt   [16];
  logic signed [31:0] cache [DEPTH];
  logic signed [31:0] rdata_r;

  logic [1:0]    in_col;
  logic [6:0]    in_par;
  logic          in_fire;
  logic [BW-1:0] bone_eff;
  logic [5:0]    slot_eff;
  logic          parent_ok;

  logic [3:0]         lidx;
  logic signed [31:0] lval, ival, a_op;
  logic signed [64:0] pr, q;
  logic signed [31:0] term;
  logic signed [33:0] sum;
  logic signed [31:0] res;
  logic               we;
  logic [AW-1:0]      waddr, raddr;
  logic signed [31:0] wdata;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign in_col     = in_tdata[1:0];
  assign in_par     = in_tdata[8:2];
  assign bone_eff   = in_tuser[0] ? '0 : bone_r;
  assign slot_eff   = in_tuser[0] ? '0 : slot_r;
  assign parent_ok  = !in_par[6] && ((BW + 6)'(in_par[5:0]) < (BW + 6)'(bone_eff));

  assign lidx = (state_r == S_RD) ? {c_r, r_r} : {c_r, k_r};
  assign lval = lbuf[lidx];
  assign ival = ibuf[{c_r, k_r}];
  assign a_op = phb_r ? opa_r : rdata_r;

  always_comb begin
    pr = {prod_r[63], prod_r} + RND;
    q  = pr >>> FRAC_BITS;
    if (q > PMAX) term = 32'sh7fffffff;
    else if (q < PMIN) term = 32'sh80000000;
    else term = q[31:0];
    sum = ((k_r == 2'd0) ? 34'sd0 : acc_r) + 34'(term);
    if (sum > SMAX) res = 32'sh7fffffff;
    else if (sum < SMIN) res = 32'sh80000000;
    else res = sum[31:0];
  end

  always_comb begin
    we    = 1'b0;
    wdata = res;
    if (state_r == S_RD && !phb_r && root_r) begin
      we    = 1'b1;
      wdata = lval;
    end else if (state_r == S_ACC && !phb_r && k_r == 2'd3) begin
      we = 1'b1;
    end
    waddr = AW'({bone_idx_r, c_r, r_r});
    raddr = AW'({parent_r, k_r, r_r});
  end

  always_ff @(posedge clk) begin
    if (we) begin
      cache[waddr] <= wdata;
      wt[{c_r, r_r}] <= wdata;
    end
    rdata_r <= cache[raddr];
    if (in_fire) begin
      for (int i = 0; i < 4; i++) begin
        lbuf[{in_col, 2'(i)}] <= in_tdata[10 + 32*i +: 32];
        ibuf[{in_col, 2'(i)}] <= in_tdata[138 + 32*i +: 32];
      end
    end
    if (state_r == S_RD) opa_r <= wt[{k_r, r_r}];
    if (state_r == S_MUL) prod_r <= a_op * (phb_r ? ival : lval);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      enable_r    <= 1'b1;
      bone_r      <= '0;
      slot_r      <= '0;
      out_valid_r <= 1'b0;
      phb_r       <= 1'b0;
      c_r         <= '0;
      r_r         <= '0;
      k_r         <= '0;
    end else begin
      if (cfg_valid && cfg_ready) enable_r <= cfg_data[0];
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            bone_r <= bone_eff;
            slot_r <= slot_eff;
            if (in_col == 2'd3 && bone_eff < BW'(MAX_BONES)) begin
              bone_r     <= bone_eff + 1'b1;
              bone_idx_r <= bone_eff;
              parent_r   <= in_par[5:0];
              root_r     <= !parent_ok;
              fin_go_r   <= in_tdata[9] && enable_r;
              oslot_r    <= slot_eff;
              if (in_tdata[9] && enable_r) slot_r <= slot_eff + 1'b1;
              phb_r      <= 1'b0;
              c_r        <= '0;
              r_r        <= '0;
              k_r        <= '0;
              state_r    <= S_RD;
            end
          end
        end
        S_RD: begin
          if (!phb_r && root_r) begin
            r_r <= r_r + 1'b1;
            if (r_r == 2'd3) begin
              c_r <= c_r + 1'b1;
              if (c_r == 2'd3) begin
                if (fin_go_r) phb_r <= 1'b1;
                else state_r <= S_IDLE;
              end
            end
          end else begin
            state_r <= S_MUL;
          end
        end
        S_MUL: state_r <= S_ACC;
        S_ACC: begin
          acc_r   <= sum;
          k_r     <= k_r + 1'b1;
          state_r <= S_RD;
          if (k_r == 2'd3) begin
            if (!phb_r) begin
              r_r <= r_r + 1'b1;
              if (r_r == 2'd3) begin
                c_r <= c_r + 1'b1;
                if (c_r == 2'd3) begin
                  if (fin_go_r) phb_r <= 1'b1;
                  else state_r <= S_IDLE;
                end
              end
            end else begin
              outv_r[c_r] <= res;
              c_r <= c_r + 1'b1;
              if (c_r == 2'd3) begin
                out_valid_r <= 1'b1;
                state_r     <= S_OUT;
              end
            end
          end
        end
        S_OUT: begin
          if (out_tready) begin
            out_valid_r <= 1'b0;
            c_r <= '0;
            if (r_r == 2'd2) begin
              phb_r   <= 1'b0;
              r_r     <= '0;
              state_r <= S_IDLE;
            end else begin
              r_r     <= r_r + 1'b1;
              state_r <= S_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = (r_r == 2'd2);
  assign out_tdata  = {outv_r[3], outv_r[2], outv_r[1], outv_r[0], r_r, oslot_r};

`ifndef SYNTHESIS
  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input open while a row waits");
  a_entry_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> in_tready)
    else $error("block busy after last row");
  a_partial_col: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tdata[1:0] != 2'd3) |=> in_tready)
    else $error("partial column beat stalled the block");
`endif

endmodule
